// ----- rtl/core/lru_page_replacement_core_defines.svh -----
// Assertion macros shared by the LRU page replacement checker.
`ifndef LRU_PAGE_REPLACEMENT_CORE_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define LRUPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define LRUPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked through reset.
`define LRUPR_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/lrupr_pkg.sv -----
// Package with widths, state encoding and cell bus types of the LRU replacement core.
`timescale 1ns / 1ps
package lrupr_pkg;

  localparam int PAGE_W     = 16;
  localparam int FRAME_W    = 4;
  localparam int CFG_W      = 5;
  localparam int STAMP_W    = 32;
  localparam int COUNT_W    = 32;
  localparam int CELL_IDX_W = 6;  // covers the largest supported frame count
  localparam int USED_W     = 7;  // holds frame counts up to 64 and any register value

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SWEEP,
    S_REPL
  } lrupr_state_t;

  // Broadcast update to all cells.
  typedef struct packed {
    logic                  clear;
    logic                  wr;
    logic [CELL_IDX_W-1:0] idx;
    logic                  fill;
    logic [31:0]           page;
    logic [STAMP_W-1:0]    stamp;
  } lrupr_cmd_t;

  // Lowest matching and lowest empty frame, rippled through the row.
  typedef struct packed {
    logic                  hit;
    logic [CELL_IDX_W-1:0] hit_idx;
    logic                  empty;
    logic [CELL_IDX_W-1:0] empty_idx;
  } lrupr_find_t;

  // Oldest-stamp token, registered in each cell.
  typedef struct packed {
    logic                  tok;
    logic                  first;
    logic [STAMP_W-1:0]    stamp;
    logic [CELL_IDX_W-1:0] idx;
    logic [31:0]           page;
  } lrupr_min_t;

endpackage

// ----- rtl/core/lrupr_if.sv -----
// Valid/ready channel interfaces for page references and replacement results.
`timescale 1ns / 1ps
interface lrupr_in_if;
  logic                        valid;
  logic                        ready;
  logic [lrupr_pkg::PAGE_W-1:0] page;
  logic                        last_reference;

  modport source (output valid, output page, output last_reference, input ready);
  modport sink   (input valid, input page, input last_reference, output ready);
endinterface

interface lrupr_out_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [lrupr_pkg::FRAME_W-1:0]  frame;
  logic                           evicted_valid;
  logic [lrupr_pkg::PAGE_W-1:0]   evicted_page;
  logic [lrupr_pkg::COUNT_W-1:0]  fault_count;

  modport source (output valid, output hit, output frame, output evicted_valid,
                  output evicted_page, output fault_count, input ready);
  modport sink   (input valid, input hit, input frame, input evicted_valid,
                  input evicted_page, input fault_count, output ready);
endinterface

// ----- rtl/core/lrupr_cell.sv -----
// One frame cell: holds valid, page and stamp, and passes find and oldest-stamp data on.
`timescale 1ns / 1ps
module lrupr_cell #(
  parameter int PAGE_BITS = 16,
  parameter int IDX       = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [PAGE_BITS-1:0]    key,
  input  logic                    in_use,
  input  lrupr_pkg::lrupr_cmd_t   cmd,
  input  lrupr_pkg::lrupr_find_t  find_i,
  output lrupr_pkg::lrupr_find_t  find_o,
  input  lrupr_pkg::lrupr_min_t   min_i,
  output lrupr_pkg::lrupr_min_t   min_o
);

  localparam logic [lrupr_pkg::CELL_IDX_W-1:0] MY_IDX = lrupr_pkg::CELL_IDX_W'(IDX);

  logic                          valid_r;
  logic [PAGE_BITS-1:0]          page_r;
  logic [lrupr_pkg::STAMP_W-1:0] stamp_r;
  lrupr_pkg::lrupr_min_t         min_r;
  lrupr_pkg::lrupr_min_t         min_nxt;
  logic                          sel;
  logic                          match;
  logic                          own_wins;

  assign sel   = cmd.wr && (cmd.idx == MY_IDX);
  assign match = valid_r && in_use && (page_r == key);

  always_comb begin
    find_o = find_i;
    if (!find_i.hit && match) begin
      find_o.hit     = 1'b1;
      find_o.hit_idx = MY_IDX;
    end
    if (!find_i.empty && in_use && !valid_r) begin
      find_o.empty     = 1'b1;
      find_o.empty_idx = MY_IDX;
    end
  end

  // Keep the older of the incoming candidate and this cell.
  assign own_wins = min_i.first || (stamp_r < min_i.stamp);

  always_comb begin
    min_nxt       = min_i;
    min_nxt.first = 1'b0;
    if (own_wins) begin
      min_nxt.stamp = stamp_r;
      min_nxt.idx   = MY_IDX;
      min_nxt.page  = 32'(page_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      min_r.tok <= 1'b0;
    end else begin
      if (cmd.clear) begin
        valid_r <= 1'b0;
      end else if (sel && cmd.fill) begin
        valid_r <= 1'b1;
      end
      // Drop the token once it leaves the frames in use.
      min_r.tok <= min_i.tok && in_use;
    end
    if (min_i.tok) begin
      min_r.first <= min_nxt.first;
      min_r.stamp <= min_nxt.stamp;
      min_r.idx   <= min_nxt.idx;
      min_r.page  <= min_nxt.page;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      stamp_r <= cmd.stamp;
      if (cmd.fill) begin
        page_r <= PAGE_BITS'(cmd.page);
      end
    end
  end

  assign min_o = min_r;

endmodule

// ----- rtl/core/lru_page_replacement_core.sv -----
// Top level of the LRU page replacement core.
// Usage:
//   in_ch carries one page reference per transaction (page, last_reference);
//   out_ch returns one result per reference (hit, frame, evicted_valid,
//   evicted_page, fault_count), in order. cfg_we/cfg_wdata write
//   frames_in_use; write it only while no reference is in flight.
// Timing:
//   A hit, or a fault that fills an empty frame, goes from accept in S_IDLE
//   to S_LOOK, which does the compare in all cells and the update once the
//   output register is free, and then back to S_IDLE. A fault on a full set
//   of frames goes on through S_SWEEP and S_REPL: the oldest-stamp token
//   walks the clamped row of cells one cell per cycle.
//   References are handled one at a time; in_ch.ready is high while idle.
// Reset clears all frames, the stamp counter, the fault count and the output
//   register, and sets frames_in_use to 16. After a reference marked last,
//   the frames, the stamp counter and the fault count are cleared as its result is produced.
// A stalled receiver holds the result in the output register; the next
//   reference is still accepted and looked up, and waits for the register.
`timescale 1ns / 1ps
module lru_page_replacement_core #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0]  cfg_wdata,
  lrupr_in_if.sink                     in_ch,
  lrupr_out_if.source                  out_ch
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  lrupr_pkg::lrupr_state_t         state_r, state_nxt;
  logic [lrupr_pkg::CFG_W-1:0]     cfg_r;
  logic [PAGE_BITS-1:0]            page_r;
  logic                            last_r;
  logic [lrupr_pkg::STAMP_W-1:0]   ref_ctr_r;
  logic [lrupr_pkg::COUNT_W-1:0]   fault_r;
  logic [lrupr_pkg::CELL_IDX_W-1:0] victim_idx_r;
  logic [31:0]                     victim_page_r;

  logic                            out_valid_r;
  logic                            out_hit_r;
  logic [lrupr_pkg::FRAME_W-1:0]   out_frame_r;
  logic                            out_ev_valid_r;
  logic [lrupr_pkg::PAGE_W-1:0]    out_ev_page_r;
  logic [lrupr_pkg::COUNT_W-1:0]   out_fault_r;

  logic [lrupr_pkg::USED_W-1:0]    used;
  logic [IDX_W-1:0]                tap;
  logic [FRAMES-1:0]               in_use;
  logic                            slot_free;

  lrupr_pkg::lrupr_cmd_t           cmd;
  lrupr_pkg::lrupr_find_t          find_o [FRAMES];
  lrupr_pkg::lrupr_min_t           min_o  [FRAMES];
  lrupr_pkg::lrupr_min_t           min_start;
  lrupr_pkg::lrupr_find_t          found;
  lrupr_pkg::lrupr_min_t           tap_min;

  logic                            apply;
  logic                            apply_hit;
  logic                            apply_ev;
  logic [lrupr_pkg::CELL_IDX_W-1:0] apply_idx;
  logic [31:0]                     apply_ev_page;
  logic                            start_sweep;
  logic [lrupr_pkg::COUNT_W-1:0]   fault_inc;

  // Clamp the frame count to 1..FRAMES.
  always_comb begin
    if (cfg_r == '0) begin
      used = lrupr_pkg::USED_W'(1);
    end else if (lrupr_pkg::USED_W'(cfg_r) > lrupr_pkg::USED_W'(FRAMES)) begin
      used = lrupr_pkg::USED_W'(FRAMES);
    end else begin
      used = lrupr_pkg::USED_W'(cfg_r);
    end
  end

  assign tap       = IDX_W'(used - lrupr_pkg::USED_W'(1));
  assign found     = find_o[FRAMES-1];
  assign tap_min   = min_o[tap];
  assign slot_free = !out_valid_r || out_ch.ready;
  assign fault_inc = (fault_r == '1) ? fault_r : fault_r + 1'b1;

  always_comb begin
    min_start       = '0;
    min_start.tok   = start_sweep;
    min_start.first = 1'b1;
  end

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lrupr_pkg::lrupr_find_t find_in;
    lrupr_pkg::lrupr_min_t  min_in;

    assign in_use[i] = lrupr_pkg::USED_W'(i) < used;

    if (i == 0) begin : g_head
      assign find_in = '0;
      assign min_in  = min_start;
    end else begin : g_link
      assign find_in = find_o[i-1];
      assign min_in  = min_o[i-1];
    end

    lrupr_cell #(
      .PAGE_BITS (PAGE_BITS),
      .IDX       (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .key    (page_r),
      .in_use (in_use[i]),
      .cmd    (cmd),
      .find_i (find_in),
      .find_o (find_o[i]),
      .min_i  (min_in),
      .min_o  (min_o[i])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrupr_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = lrupr_pkg::S_LOOK;
        end
      end
      lrupr_pkg::S_LOOK: begin
        if (found.hit || found.empty) begin
          if (slot_free) begin
            state_nxt = lrupr_pkg::S_IDLE;
          end
        end else begin
          state_nxt = lrupr_pkg::S_SWEEP;
        end
      end
      lrupr_pkg::S_SWEEP: begin
        if (tap_min.tok) begin
          state_nxt = lrupr_pkg::S_REPL;
        end
      end
      lrupr_pkg::S_REPL: begin
        if (slot_free) begin
          state_nxt = lrupr_pkg::S_IDLE;
        end
      end
      default: state_nxt = lrupr_pkg::S_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_ch.ready   = 1'b0;
    apply         = 1'b0;
    apply_hit     = 1'b0;
    apply_ev      = 1'b0;
    apply_idx     = '0;
    apply_ev_page = '0;
    start_sweep   = 1'b0;
    unique case (state_r)
      lrupr_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
      end
      lrupr_pkg::S_LOOK: begin
        if (found.hit) begin
          apply     = slot_free;
          apply_hit = 1'b1;
          apply_idx = found.hit_idx;
        end else if (found.empty) begin
          apply     = slot_free;
          apply_idx = found.empty_idx;
        end else begin
          start_sweep = 1'b1;
        end
      end
      lrupr_pkg::S_SWEEP: begin
      end
      lrupr_pkg::S_REPL: begin
        apply         = slot_free;
        apply_ev      = 1'b1;
        apply_idx     = victim_idx_r;
        apply_ev_page = victim_page_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.clear = apply && last_r;
    cmd.wr    = apply;
    cmd.idx   = apply_idx;
    cmd.fill  = !apply_hit;
    cmd.page  = 32'(page_r);
    cmd.stamp = ref_ctr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrupr_pkg::S_IDLE;
      cfg_r       <= lrupr_pkg::CFG_RESET;
      ref_ctr_r   <= '0;
      fault_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (apply) begin
        if (last_r) begin
          ref_ctr_r <= '0;
          fault_r   <= '0;
        end else begin
          ref_ctr_r <= ref_ctr_r + 1'b1;
          if (!apply_hit) begin
            fault_r <= fault_inc;
          end
        end
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      page_r <= PAGE_BITS'(in_ch.page);
      last_r <= in_ch.last_reference;
    end
    if (state_r == lrupr_pkg::S_SWEEP && tap_min.tok) begin
      victim_idx_r  <= tap_min.idx;
      victim_page_r <= tap_min.page;
    end
    if (apply) begin
      out_hit_r      <= apply_hit;
      out_frame_r    <= apply_idx[lrupr_pkg::FRAME_W-1:0];
      out_ev_valid_r <= apply_ev;
      out_ev_page_r  <= lrupr_pkg::PAGE_W'(apply_ev_page);
      out_fault_r    <= apply_hit ? fault_r : fault_inc;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.hit           = out_hit_r;
  assign out_ch.frame         = out_frame_r;
  assign out_ch.evicted_valid = out_ev_valid_r;
  assign out_ch.evicted_page  = out_ev_page_r;
  assign out_ch.fault_count   = out_fault_r;

endmodule

// ----- rtl/core/lrupr_checker.sv -----
// Port-level checker for the LRU page replacement core, with its bind.
`timescale 1ns / 1ps
`include "lru_page_replacement_core_defines.svh"
module lrupr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_hit,
  input logic                           out_evicted_valid,
  input logic [lrupr_pkg::PAGE_W-1:0]   out_evicted_page,
  input logic [lrupr_pkg::COUNT_W-1:0]  out_fault_count
);

  // Reset empties the output register.
  `LRUPR_ASSERT_NEXT_ALWAYS(a_reset_drains, clk, !rst_n, !out_valid, "result valid after reset")

  // One reference at a time: no accept right after an accept.
  `LRUPR_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "accepted back to back")

  // A hit never evicts.
  `LRUPR_ASSERT_NOW(a_hit_no_evict, clk, rst_n, out_valid && out_hit, !out_evicted_valid, "hit with eviction")

  // Without eviction the evicted page reads zero.
  `LRUPR_ASSERT_NOW(a_ev_page_zero, clk, rst_n, out_valid && !out_evicted_valid, out_evicted_page == '0, "evicted page not zero")

  // A stalled result holds.
  `LRUPR_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_fault_count), "stalled result changed")

endmodule

bind lru_page_replacement_core lrupr_checker u_lrupr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_hit           (out_ch.hit),
  .out_evicted_valid (out_ch.evicted_valid),
  .out_evicted_page  (out_ch.evicted_page),
  .out_fault_count   (out_ch.fault_count)
);
